@@ src/ecrs_pkg.sv @@
// Shared types and codes for the elevator car request scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package ecrs_pkg;

  localparam int FLOOR_W    = 5;
  localparam int CAP_W      = 8;
  localparam int HEAT_W     = 8;
  localparam int WEIGHT_W   = 16;
  localparam int KIND_W     = 3;
  localparam int DIR_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [KIND_W-1:0] KIND_BOARD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNLOAD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STEP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FIND    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SET_DIR = 3'd5;

  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIDER_CAP   = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [FLOOR_W-1:0]  dest_floor;
    logic [HEAT_W-1:0]   rider_heat;
    logic [WEIGHT_W-1:0] rider_weight;
    logic [DIR_W-1:0]    new_direction;
  } in_t;

  typedef struct packed {
    logic [FLOOR_W-1:0]  car_floor;
    logic [FLOOR_W-1:0]  found_floor;
    logic [FLOOR_W-1:0]  pending_target;
    logic [CAP_W-1:0]    riders_aboard;
    logic [HEAT_W-1:0]   car_heat;
    logic [WEIGHT_W-1:0] car_load;
    logic                accepted;
  } out_t;

  typedef struct packed {
    logic [CAP_W-1:0]    count;
    logic [HEAT_W-1:0]   heat;
    logic [WEIGHT_W-1:0] weight;
  } floor_sum_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_find;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/elevator_car_request_scheduler.sv @@
// Top level of the elevator car request scheduler.
// Depends on ecrs_pkg, ecrs_controller and ecrs_datapath.
//
// Usage:
//   in_valid/in_stall/in_data carry one command per beat (board, unload, step,
//   find next, request floor, set direction). out_valid/out_stall/out_data
//   return one result beat per command: the car state after that command.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write floor_count (index 0) and
//   rider_capacity (index 1); cfg_ready is always high. Write only when idle.
// Timing:
//   A command is taken in IDLE, executed in EXEC, then for find next scanned
//   in SCAN, and its result is loaded into the output register in EMIT once
//   that register is free; the next command is taken back in IDLE. Find next
//   walks the request marks one floor per cycle, first in the car's direction
//   then the opposite one. One command is in flight at a time.
// Reset:
//   rst_n low clears the car to floor 0, direction stop, no requests, empty
//   floors, heat at ROOM_HEAT; floor_count 16, rider_capacity 8.
// Stall:
//   A result held by out_stall stays in the output register; the block takes
//   the next command meanwhile and holds its result until the register frees.
module elevator_car_request_scheduler import ecrs_pkg::*; #(
  parameter int MAX_FLOORS = 16,
  parameter int ROOM_HEAT  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      busy;

  ecrs_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  ecrs_datapath #(
    .MAX_FLOORS (MAX_FLOORS),
    .ROOM_HEAT  (ROOM_HEAT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking a command");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a command in progress");

  a_find_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.found_floor != '0) |-> !out_data.accepted)
    else $error("found floor reported together with accepted");

endmodule

@@ src/ecrs_controller.sv @@
// Sequencer for the scheduler: take, execute, scan, emit.
// Depends on ecrs_pkg; drives commands into ecrs_datapath.
module ecrs_controller import ecrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = sts.is_find ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.take = (state_r == S_IDLE) && in_valid;
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.scan = (state_r == S_SCAN);
  assign cmd.emit = (state_r == S_EMIT) && sts.out_free;
  assign busy     = (state_r != S_IDLE);

endmodule

@@ src/ecrs_datapath.sv @@
// Car state, per-floor sum memory, request marks, floor scan and result register.
// Depends on ecrs_pkg; commanded by ecrs_controller.
module ecrs_datapath import ecrs_pkg::*; #(
  parameter int MAX_FLOORS = 16,
  parameter int ROOM_HEAT  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  in_t                   in_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_t                  out_data
);

  localparam int IDX_W       = $clog2(MAX_FLOORS);
  localparam int SERVE_CAP_I = (MAX_FLOORS < 31) ? MAX_FLOORS : 31;
  localparam logic [FLOOR_W-1:0] SERVE_CAP = FLOOR_W'(SERVE_CAP_I);

  function automatic logic [IDX_W-1:0] to_idx(input logic [FLOOR_W-1:0] fl);
    logic [FLOOR_W-1:0] d;
    d = fl - FLOOR_W'(1);
    return IDX_W'(d);
  endfunction

  logic [FLOOR_W-1:0]  floor_count_r;
  logic [CAP_W-1:0]    rider_cap_r;
  logic [FLOOR_W-1:0]  floor_now_r,     floor_now_nxt;
  logic [DIR_W-1:0]    dir_r,           dir_nxt;
  logic [FLOOR_W-1:0]  first_target_r,  first_target_nxt;
  logic [MAX_FLOORS-1:0] marks_r,       marks_nxt;
  logic [MAX_FLOORS-1:0] sum_valid_r,   sum_valid_nxt;
  logic [CAP_W-1:0]    headcount_r,     headcount_nxt;
  logic [HEAT_W-1:0]   heat_total_r,    heat_total_nxt;
  logic [WEIGHT_W-1:0] weight_total_r,  weight_total_nxt;
  logic [FLOOR_W-1:0]  ptr_r,           ptr_nxt;
  logic [DIR_W-1:0]    scan_dir_r,      scan_dir_nxt;
  logic                scan_second_r,   scan_second_nxt;
  logic [FLOOR_W-1:0]  found_r,         found_nxt;
  logic                acc_r,           acc_nxt;
  in_t                 cmd_data_r;
  floor_sum_t          rd_data_r;
  logic                rd_valid_r;
  logic                out_valid_r;
  out_t                out_data_r;

  floor_sum_t          sum_mem [MAX_FLOORS];

  logic [FLOOR_W-1:0]  served;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    cur_idx;
  floor_sum_t          cur_sum;
  floor_sum_t          wr_data;
  logic                wr_en;
  logic                dest_ok;
  logic                board_ok;
  logic                unload_ok;
  logic [FLOOR_W-1:0]  start_up;
  logic [FLOOR_W-1:0]  start_down;
  logic [DIR_W-1:0]    second_dir;
  logic                in_range;
  logic                hit;

  assign served     = (floor_count_r > SERVE_CAP) ? SERVE_CAP : floor_count_r;
  assign rd_idx     = (in_data.kind == KIND_UNLOAD) ? to_idx(floor_now_r)
                                                    : to_idx(in_data.dest_floor);
  assign cur_idx    = (cmd_data_r.kind == KIND_UNLOAD) ? to_idx(floor_now_r)
                                                       : to_idx(cmd_data_r.dest_floor);
  assign cur_sum    = rd_valid_r ? rd_data_r : '0;
  assign dest_ok    = (cmd_data_r.dest_floor != '0) && (cmd_data_r.dest_floor <= served);
  assign board_ok   = (headcount_r < rider_cap_r) && dest_ok;
  assign unload_ok  = (floor_now_r != '0) && (int'(floor_now_r) <= MAX_FLOORS);
  assign start_up   = (floor_now_r == '0) ? FLOOR_W'(1) : floor_now_r;
  assign start_down = (start_up > served) ? served : start_up;
  assign second_dir = (dir_r == DIR_UP) ? DIR_DOWN : DIR_UP;
  assign in_range   = (served != '0) && (ptr_r != '0) && (ptr_r <= served) &&
                      ((scan_dir_r == DIR_UP) || (scan_dir_r == DIR_DOWN));
  assign hit        = in_range && marks_r[to_idx(ptr_r)];

  assign wr_en          = cmd.exec && (cmd_data_r.kind == KIND_BOARD) && board_ok;
  assign wr_data.count  = cur_sum.count + CAP_W'(1);
  assign wr_data.heat   = cur_sum.heat + cmd_data_r.rider_heat;
  assign wr_data.weight = cur_sum.weight + cmd_data_r.rider_weight;

  always_comb begin
    floor_now_nxt    = floor_now_r;
    dir_nxt          = dir_r;
    first_target_nxt = first_target_r;
    marks_nxt        = marks_r;
    sum_valid_nxt    = sum_valid_r;
    headcount_nxt    = headcount_r;
    heat_total_nxt   = heat_total_r;
    weight_total_nxt = weight_total_r;
    ptr_nxt          = ptr_r;
    scan_dir_nxt     = scan_dir_r;
    scan_second_nxt  = scan_second_r;
    found_nxt        = found_r;
    acc_nxt          = acc_r;
    if (cmd.exec) begin
      found_nxt = '0;
      acc_nxt   = 1'b0;
      case (cmd_data_r.kind)
        KIND_BOARD: begin
          if (board_ok) begin
            headcount_nxt          = headcount_r + CAP_W'(1);
            heat_total_nxt         = heat_total_r + cmd_data_r.rider_heat;
            weight_total_nxt       = weight_total_r + cmd_data_r.rider_weight;
            marks_nxt[cur_idx]     = 1'b1;
            sum_valid_nxt[cur_idx] = 1'b1;
            acc_nxt                = 1'b1;
          end
        end
        KIND_UNLOAD: begin
          if (unload_ok) begin
            headcount_nxt          = headcount_r - cur_sum.count;
            heat_total_nxt         = heat_total_r - cur_sum.heat;
            weight_total_nxt       = weight_total_r - cur_sum.weight;
            marks_nxt[cur_idx]     = 1'b0;
            sum_valid_nxt[cur_idx] = 1'b0;
          end
        end
        KIND_STEP: begin
          if ((dir_r == DIR_UP) && (floor_now_r < served)) begin
            floor_now_nxt = floor_now_r + FLOOR_W'(1);
          end else if ((dir_r == DIR_DOWN) && (floor_now_r > FLOOR_W'(1))) begin
            floor_now_nxt = floor_now_r - FLOOR_W'(1);
          end
        end
        KIND_FIND: begin
          scan_dir_nxt    = dir_r;
          scan_second_nxt = 1'b0;
          ptr_nxt         = (dir_r == DIR_DOWN) ? start_down : start_up;
        end
        KIND_REQUEST: begin
          if (dest_ok) begin
            marks_nxt[cur_idx] = 1'b1;
            if (first_target_r == '0) first_target_nxt = cmd_data_r.dest_floor;
            acc_nxt = 1'b1;
          end
        end
        KIND_SET_DIR: begin
          if (cmd_data_r.new_direction <= DIR_DOWN) dir_nxt = cmd_data_r.new_direction;
        end
        default: begin
        end
      endcase
    end else if (cmd.scan) begin
      if (hit) begin
        found_nxt = ptr_r;
      end else if (in_range) begin
        ptr_nxt = (scan_dir_r == DIR_UP) ? ptr_r + FLOOR_W'(1) : ptr_r - FLOOR_W'(1);
      end else if (!scan_second_r) begin
        scan_second_nxt = 1'b1;
        scan_dir_nxt    = second_dir;
        ptr_nxt         = (second_dir == DIR_DOWN) ? start_down : start_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_count_r  <= FLOOR_W'(16);
      rider_cap_r    <= CAP_W'(8);
      floor_now_r    <= '0;
      dir_r          <= DIR_STOP;
      first_target_r <= '0;
      marks_r        <= '0;
      sum_valid_r    <= '0;
      headcount_r    <= '0;
      heat_total_r   <= HEAT_W'(ROOM_HEAT);
      weight_total_r <= '0;
      scan_dir_r     <= DIR_STOP;
      scan_second_r  <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_FLOOR_COUNT: floor_count_r <= cfg_data[FLOOR_W-1:0];
          REG_RIDER_CAP:   rider_cap_r   <= cfg_data[CAP_W-1:0];
          default: begin
          end
        endcase
      end
      floor_now_r    <= floor_now_nxt;
      dir_r          <= dir_nxt;
      first_target_r <= first_target_nxt;
      marks_r        <= marks_nxt;
      sum_valid_r    <= sum_valid_nxt;
      headcount_r    <= headcount_nxt;
      heat_total_r   <= heat_total_nxt;
      weight_total_r <= weight_total_nxt;
      scan_dir_r     <= scan_dir_nxt;
      scan_second_r  <= scan_second_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    found_r <= found_nxt;
    acc_r   <= acc_nxt;
    if (cmd.take) begin
      cmd_data_r <= in_data;
      rd_valid_r <= sum_valid_r[rd_idx];
    end
    if (cmd.emit) begin
      out_data_r.car_floor      <= floor_now_r;
      out_data_r.found_floor    <= found_r;
      out_data_r.pending_target <= first_target_r;
      out_data_r.riders_aboard  <= headcount_r;
      out_data_r.car_heat       <= heat_total_r;
      out_data_r.car_load       <= weight_total_r;
      out_data_r.accepted       <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) rd_data_r <= sum_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (wr_en) sum_mem[cur_idx] <= wr_data;
  end

  assign sts.is_find   = (cmd_data_r.kind == KIND_FIND);
  assign sts.scan_done = hit || (!in_range && scan_second_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/sv/ecrs_checker.sv @@
// Checker for the elevator car request scheduler: watches the command, result and
// register write channels, predicts each result beat and compares it field by field.
// Depends on ecrs_pkg.
module ecrs_checker import ecrs_pkg::*; #(
  parameter int MAX_FLOORS = 16,
  parameter int ROOM_HEAT  = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_t                  out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [FLOOR_W-1:0]  floors_cfg;
  logic [CAP_W-1:0]    capacity_cfg;
  logic [FLOOR_W-1:0]  car_at;
  logic [FLOOR_W-1:0]  first_call;
  logic [DIR_W-1:0]    heading;
  logic [MAX_FLOORS:1] calls;
  floor_sum_t          bound_for [1:MAX_FLOORS];
  logic [CAP_W-1:0]    aboard;
  logic [HEAT_W-1:0]   heat_now;
  logic [WEIGHT_W-1:0] load_now;
  out_t                car_state_q [$];
  int                  beat_no;

  function automatic int served_floors();
    int n;
    n = floors_cfg;
    if (n > MAX_FLOORS) n = MAX_FLOORS;
    return n;
  endfunction

  function automatic logic [FLOOR_W-1:0] scan_calls(logic [DIR_W-1:0] d);
    int n;
    int start;
    int f;
    n = served_floors();
    start = (car_at < 1) ? 1 : int'(car_at);
    if (n == 0) return '0;
    if (d == DIR_UP) begin
      for (f = start; f <= n; f++)
        if (calls[f]) return FLOOR_W'(f);
    end else if (d == DIR_DOWN) begin
      if (start > n) start = n;
      for (f = start; f >= 1; f--)
        if (calls[f]) return FLOOR_W'(f);
    end
    return '0;
  endfunction

  task automatic run_car_command(input in_t c, output out_t r);
    int n;
    int i;
    logic [FLOOR_W-1:0] hit;
    logic took;
    n = served_floors();
    hit = '0;
    took = 1'b0;
    case (c.kind)
      KIND_BOARD: begin
        if (aboard < capacity_cfg && c.dest_floor >= 1 && c.dest_floor <= n) begin
          i = int'(c.dest_floor);
          bound_for[i].count  += CAP_W'(1);
          bound_for[i].heat   += c.rider_heat;
          bound_for[i].weight += c.rider_weight;
          aboard   += CAP_W'(1);
          heat_now += c.rider_heat;
          load_now += c.rider_weight;
          calls[i] = 1'b1;
          took = 1'b1;
        end
      end
      KIND_UNLOAD: begin
        if (car_at >= 1 && car_at <= MAX_FLOORS) begin
          i = int'(car_at);
          aboard   -= bound_for[i].count;
          heat_now -= bound_for[i].heat;
          load_now -= bound_for[i].weight;
          bound_for[i] = '0;
          calls[i] = 1'b0;
        end
      end
      KIND_STEP: begin
        if (heading == DIR_UP && car_at < n) car_at += FLOOR_W'(1);
        else if (heading == DIR_DOWN && car_at > 1) car_at -= FLOOR_W'(1);
      end
      KIND_FIND: begin
        hit = scan_calls(heading);
        if (hit == 0) hit = scan_calls(heading == DIR_UP ? DIR_DOWN : DIR_UP);
      end
      KIND_REQUEST: begin
        if (c.dest_floor >= 1 && c.dest_floor <= n) begin
          calls[c.dest_floor] = 1'b1;
          if (first_call == 0) first_call = c.dest_floor;
          took = 1'b1;
        end
      end
      KIND_SET_DIR: begin
        if (c.new_direction <= DIR_DOWN) heading = c.new_direction;
      end
      default: ;
    endcase
    r.car_floor      = car_at;
    r.found_floor    = hit;
    r.pending_target = first_call;
    r.riders_aboard  = aboard;
    r.car_heat       = heat_now;
    r.car_load       = load_now;
    r.accepted       = took;
  endtask

  task automatic report_error(input string msg);
    if (error_count < 100) $display("%0t ecrs_checker: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result beat %0d: %s is %0d, expected %0d",
                             beat_no, name, got, want));
  endtask

  task automatic compare_result(input out_t got);
    out_t want;
    if (car_state_q.size() == 0) begin
      report_error($sformatf("result beat %0d arrived with none expected", beat_no));
    end else begin
      want = car_state_q.pop_front();
      check_field("car_floor", got.car_floor, want.car_floor);
      check_field("found_floor", got.found_floor, want.found_floor);
      check_field("pending_target", got.pending_target, want.pending_target);
      check_field("riders_aboard", got.riders_aboard, want.riders_aboard);
      check_field("car_heat", got.car_heat, want.car_heat);
      check_field("car_load", got.car_load, want.car_load);
      check_field("accepted", got.accepted, want.accepted);
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    out_t predicted;
    if (!rst_n) begin
      floors_cfg   = FLOOR_W'(16);
      capacity_cfg = CAP_W'(8);
      car_at       = '0;
      first_call   = '0;
      heading      = DIR_STOP;
      calls        = '0;
      for (int f = 1; f <= MAX_FLOORS; f++) bound_for[f] = '0;
      aboard       = '0;
      heat_now     = HEAT_W'(ROOM_HEAT);
      load_now     = '0;
      car_state_q.delete();
      beat_no      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FLOOR_COUNT) floors_cfg = cfg_data[FLOOR_W-1:0];
        else if (cfg_index == REG_RIDER_CAP) capacity_cfg = cfg_data[CAP_W-1:0];
      end
      if (in_valid && !in_stall) begin
        run_car_command(in_data, predicted);
        car_state_q.push_back(predicted);
      end
      if (out_valid && !out_stall) compare_result(out_data);
    end
    results_owed = car_state_q.size();
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the elevator car request scheduler: clock, reset, command
// and register write stimulus, result back-pressure, watchdog and verdict.
// Depends on ecrs_pkg, elevator_car_request_scheduler and ecrs_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecrs_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAX_FLOORS  = 16;
  localparam int ROOM_HEAT   = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 30;
  localparam int STALE_LIMIT = 5000;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [DIR_W-1:0]  DIR_BAD       = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    error_count;
  int                    results_owed;
  bit                    steady;
  bit                    hold_req;

  always #(CLK_PERIOD / 2) clk = ~clk;

  elevator_car_request_scheduler #(
    .MAX_FLOORS(MAX_FLOORS),
    .ROOM_HEAT (ROOM_HEAT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ecrs_checker #(
    .MAX_FLOORS(MAX_FLOORS),
    .ROOM_HEAT (ROOM_HEAT)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .results_owed(results_owed)
  );

  function automatic in_t make_cmd(input logic [KIND_W-1:0] kind,
                                   input logic [FLOOR_W-1:0] dest = '0,
                                   input logic [HEAT_W-1:0] heat = '0,
                                   input logic [WEIGHT_W-1:0] weight = '0,
                                   input logic [DIR_W-1:0] dir = DIR_STOP);
    in_t c;
    c.kind          = kind;
    c.dest_floor    = dest;
    c.rider_heat    = heat;
    c.rider_weight  = weight;
    c.new_direction = dir;
    return c;
  endfunction

  function automatic in_t random_command();
    in_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) c.kind = KIND_BOARD;
    else if (roll < 42) c.kind = KIND_UNLOAD;
    else if (roll < 62) c.kind = KIND_STEP;
    else if (roll < 74) c.kind = KIND_FIND;
    else if (roll < 86) c.kind = KIND_REQUEST;
    else if (roll < 98) c.kind = KIND_SET_DIR;
    else c.kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    c.dest_floor   = FLOOR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 17));
    c.rider_heat   = HEAT_W'($urandom_range(0, 255));
    c.rider_weight = WEIGHT_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 19) == 0) begin
      c.rider_heat   = '1;
      c.rider_weight = '1;
    end
    roll = $urandom_range(0, 19);
    if (roll == 0) c.new_direction = DIR_BAD;
    else if (roll < 9) c.new_direction = DIR_UP;
    else if (roll < 17) c.new_direction = DIR_DOWN;
    else c.new_direction = DIR_STOP;
    return c;
  endfunction

  task automatic offer_command(input in_t c);
    while (!steady && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] floors,
                            input logic [CFG_DATA_W-1:0] capacity);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FLOOR_COUNT;
    cfg_data  <= floors;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_RIDER_CAP;
    cfg_data  <= capacity;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] floors,
                           input logic [CFG_DATA_W-1:0] capacity,
                           input int items, input bit no_gaps, input bit hold);
    set_config(floors, capacity);
    steady = no_gaps;
    if (hold) hold_req = 1'b1;
    repeat (items) offer_command(random_command());
    wait_idle();
    steady = 1'b0;
  endtask

  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 22);
    end
  end

  initial begin : watchdog
    int stale;
    stale = 0;
    while (stale < STALE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        stale = 0;
      else
        stale++;
    end
    $display("** elevator_car_request_scheduler: FAILED **");
    $finish;
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer_command(make_cmd(KIND_FIND));
    offer_command(make_cmd(KIND_UNLOAD));
    offer_command(make_cmd(KIND_STEP));
    offer_command(make_cmd(KIND_SET_DIR, '0, '0, '0, DIR_BAD));
    offer_command(make_cmd(KIND_SPARE_LO, 5'd3, 8'd9, 16'd100, DIR_UP));
    offer_command(make_cmd(KIND_SPARE_HI, '1, '1, '1, DIR_BAD));
    offer_command(make_cmd(KIND_REQUEST, 5'd0));
    offer_command(make_cmd(KIND_REQUEST, 5'd17));
    offer_command(make_cmd(KIND_REQUEST, 5'd31));
    offer_command(make_cmd(KIND_REQUEST, 5'd16));
    offer_command(make_cmd(KIND_REQUEST, 5'd1));
    offer_command(make_cmd(KIND_BOARD, 5'd0, 8'd5, 16'd5));
    offer_command(make_cmd(KIND_BOARD, 5'd16, '1, '1));
    offer_command(make_cmd(KIND_BOARD, 5'd1, '0, '0));
    offer_command(make_cmd(KIND_SET_DIR, '0, '0, '0, DIR_UP));
    offer_command(make_cmd(KIND_STEP));
    offer_command(make_cmd(KIND_FIND));
    offer_command(make_cmd(KIND_UNLOAD));
    offer_command(make_cmd(KIND_FIND));
    offer_command(make_cmd(KIND_SET_DIR, '0, '0, '0, DIR_DOWN));
    offer_command(make_cmd(KIND_FIND));
    offer_command(make_cmd(KIND_SET_DIR, '0, '0, '0, DIR_STOP));
    offer_command(make_cmd(KIND_FIND));
    repeat (7) offer_command(make_cmd(KIND_BOARD, 5'd2, 8'd200, 16'd40000));
    wait_idle();

    run_phase(8'd16, 8'd8, 200, 1'b0, 1'b0);
    run_phase(8'd5, 8'd20, 200, 1'b0, 1'b1);
    run_phase(8'd1, 8'd1, 150, 1'b0, 1'b0);
    run_phase(8'd16, 8'd255, 250, 1'b1, 1'b0);
    run_phase(8'd0, 8'd0, 100, 1'b0, 1'b0);
    run_phase(8'd31, 8'd3, 200, 1'b0, 1'b0);
    run_phase(8'd2, 8'd255, 150, 1'b0, 1'b0);
    run_phase(8'd200, 8'd4, 200, 1'b0, 1'b0);
    run_phase(CFG_DATA_W'($urandom_range(1, 16)), CFG_DATA_W'($urandom_range(1, 255)),
              250, 1'b0, 1'b0);

    repeat (SETTLE) @(negedge clk);
    if (error_count == 0)
      $display("** elevator_car_request_scheduler: PASSED **");
    else
      $display("** elevator_car_request_scheduler: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
src/ecrs_pkg.sv
src/ecrs_controller.sv
src/ecrs_datapath.sv
src/elevator_car_request_scheduler.sv
tb/sv/ecrs_checker.sv
tb/sv/tb.sv
